>>> rtl/dplrg_pkg.sv
// ----------------------------------------------------------------------------
// dplrg_pkg: shared codes for the depth point lift and reprojection gate
// Status codes, function codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package dplrg_pkg;

  typedef enum logic [2:0] {
    ST_SKIP   = 3'd0,
    ST_VIA_A  = 3'd1,
    ST_VIA_B  = 3'd2,
    ST_REJECT = 3'd3,
    ST_POSE   = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_POSE    = 1'b0,
    FUNC_FEATURE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_MIN_DEPTH = 1'b0,
    CFG_RES_LIMIT = 1'b1
  } cfg_idx_e;

  localparam logic [30:0] MIN_DEPTH_RST = 31'd104858;
  localparam logic [39:0] RES_LIMIT_RST = 40'd5196066;

  localparam int unsigned POSE_WORDS = 12;
  localparam logic [4:0]  POSE_B_BASE = 5'd12;
  localparam logic [4:0]  POSE_SLOTS  = 5'd24;

endpackage

>>> rtl/depth_point_lift_reprojection_gate.sv
// ----------------------------------------------------------------------------
// depth_point_lift_reprojection_gate
// Lifts a feature to world space through one pose and gates it by its
// reprojection residual in the other pose.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o) carries either a pose
// word load (func 0) or a feature (func 1). Every transaction yields exactly
// one result on the output channel (out_valid_o / out_ready_i), in order.
// Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i while
// the block is idle.
// The pipeline has 42 + FRAC_BITS register stages: six arithmetic stages, one
// divider setup stage, one restoring divider stage per quotient bit
// (32 + FRAC_BITS), then residual, square and gate stages.
// Throughput is one feature per cycle while the output is not stalled.
// A pose load waits at the input until no feature sits in the first five
// stages, which read the pose words.
// Each stage holds its transaction until the next stage frees up, so a
// stalled receiver fills the empty stages before the input backs up.
// Reset clears the stage valid bits and loads the register defaults; the
// pose words are undefined until loaded.
// ----------------------------------------------------------------------------
module depth_point_lift_reprojection_gate
  import dplrg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [39:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_func_i,
  input  logic [4:0]         in_pose_slot_i,
  input  logic signed [31:0] in_pose_word_i,
  input  logic               in_placed_i,
  input  logic               in_has_a_i,
  input  logic               in_has_b_i,
  input  logic signed [31:0] in_xa_i,
  input  logic signed [31:0] in_ya_i,
  input  logic [30:0]        in_da_i,
  input  logic signed [31:0] in_xb_i,
  input  logic signed [31:0] in_yb_i,
  input  logic [30:0]        in_db_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         out_status_o,
  output logic signed [31:0] out_world_x_o,
  output logic signed [31:0] out_world_y_o,
  output logic signed [31:0] out_world_z_o
);

  localparam int unsigned QW   = 32 + FRAC_BITS;
  localparam int unsigned DIV0 = 7;
  localparam int unsigned RES  = DIV0 + QW;
  localparam int unsigned SQ   = RES + 1;
  localparam int unsigned OUTS = SQ + 1;
  localparam int unsigned NS   = OUTS + 1;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0]        status;
    logic              alive;
    logic              via_b;
    logic [31:0]       ox;
    logic [31:0]       oy;
    logic [2:0][31:0]  e;
    logic [2:0][31:0]  w;
    logic [8:0][63:0]  prod;
    logic              neg_x;
    logic              neg_y;
    logic [30:0]       divisor;
    logic [30:0]       rem_x;
    logic [30:0]       rem_y;
    logic [QW-1:0]     rq_x;
    logic [QW-1:0]     rq_y;
    logic [31:0]       m_x;
    logic [31:0]       m_y;
  } stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    return (p + HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [31:0] mag_clamp(input logic signed [QW+1:0] r);
    logic [QW+1:0] m;
    m = r[QW+1] ? 0 - r : r;
    if (m > (QW+2)'(33'h0_8000_0000)) begin
      return 32'h8000_0000;
    end
    return m[31:0];
  endfunction

  logic [30:0]        min_depth_q;
  logic [39:0]        res_limit_q;
  logic signed [31:0] pa_q [POSE_WORDS];
  logic signed [31:0] pb_q [POSE_WORDS];
  stage_t             st_q [NS];
  stage_t             st_d [NS];
  logic [NS-1:0]      v_q;
  logic [NS-1:0]      mv;
  logic               in_accept;
  logic               feat_busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q <= MIN_DEPTH_RST;
      res_limit_q <= RES_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_DEPTH: min_depth_q <= cfg_wdata_i[30:0];
        CFG_RES_LIMIT: res_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold a pose load while any feature still has pose reads ahead of it.
  always_comb begin
    feat_busy = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (v_q[k] && st_q[k].status != ST_POSE) begin
        feat_busy = 1'b1;
      end
    end
  end

  always_comb begin
    mv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      mv[k] = !v_q[k] || mv[k+1];
    end
  end

  assign in_ready_o = mv[0] && (in_func_i == FUNC_FEATURE || !feat_busy);
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept && in_func_i == FUNC_POSE) begin
      if (in_pose_slot_i < POSE_B_BASE) begin
        pa_q[in_pose_slot_i[3:0]] <= in_pose_word_i;
      end else if (in_pose_slot_i < POSE_SLOTS) begin
        pb_q[4'(in_pose_slot_i - POSE_B_BASE)] <= in_pose_word_i;
      end
    end
  end

  always_comb begin
    logic signed [31:0] x, y, rs, ts, pk;
    logic signed [31:0] d;
    logic signed [63:0] acc;
    logic [31:0]        tx, ty;
    logic               gx, gy;
    logic signed [QW:0] ux, uy;
    logic [31:0]        mag_x, mag_y;

    // Stage 0: classify and form x*d, y*d
    st_d[0] = '0;
    x = in_xa_i;
    y = in_ya_i;
    d = {1'b0, in_da_i};
    st_d[0].ox = in_xb_i;
    st_d[0].oy = in_yb_i;
    if (in_func_i == FUNC_POSE) begin
      st_d[0].status = ST_POSE;
    end else if (in_placed_i || !in_has_a_i || !in_has_b_i) begin
      st_d[0].status = ST_SKIP;
    end else if (in_da_i > min_depth_q) begin
      st_d[0].status = ST_VIA_A;
      st_d[0].alive  = 1'b1;
    end else if (in_db_i > min_depth_q) begin
      st_d[0].status = ST_VIA_B;
      st_d[0].alive  = 1'b1;
      st_d[0].via_b  = 1'b1;
      x = in_xb_i;
      y = in_yb_i;
      d = {1'b0, in_db_i};
      st_d[0].ox = in_xa_i;
      st_d[0].oy = in_ya_i;
    end else begin
      st_d[0].status = ST_SKIP;
    end
    st_d[0].prod[0] = smul(x, d);
    st_d[0].prod[1] = smul(y, d);
    st_d[0].e[2]    = d;

    // Stage 1: e = p - t_src
    st_d[1] = st_q[0];
    for (int k = 0; k < 3; k++) begin
      ts = st_q[0].via_b ? pb_q[4'(k*4+3)] : pa_q[4'(k*4+3)];
      pk = (k == 2) ? $signed(st_q[0].e[2])
                    : sat32(66'(rnd($signed(st_q[0].prod[k]))));
      st_d[1].e[k] = sat32(66'(pk) - 66'(ts));
    end

    // Stage 2: R_src^T products
    st_d[2] = st_q[1];
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rs = st_q[1].via_b ? pb_q[4'(k*4+i)] : pa_q[4'(k*4+i)];
        st_d[2].prod[i*3+k] = smul(rs, $signed(st_q[1].e[k]));
      end
    end

    // Stage 3: world point
    st_d[3] = st_q[2];
    for (int i = 0; i < 3; i++) begin
      acc = rnd($signed(st_q[2].prod[i*3])) + rnd($signed(st_q[2].prod[i*3+1]))
          + rnd($signed(st_q[2].prod[i*3+2]));
      st_d[3].w[i] = sat32(66'(acc));
    end

    // Stage 4: R_dst products
    st_d[4] = st_q[3];
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rs = st_q[3].via_b ? pa_q[4'(i*4+k)] : pb_q[4'(i*4+k)];
        st_d[4].prod[i*3+k] = smul(rs, $signed(st_q[3].w[k]));
      end
    end

    // Stage 5: reprojected point, depth gate
    st_d[5] = st_q[4];
    for (int i = 0; i < 3; i++) begin
      ts = st_q[4].via_b ? pa_q[4'(i*4+3)] : pb_q[4'(i*4+3)];
      acc = 64'(ts) + rnd($signed(st_q[4].prod[i*3]))
          + rnd($signed(st_q[4].prod[i*3+1])) + rnd($signed(st_q[4].prod[i*3+2]));
      st_d[5].e[i] = sat32(66'(acc));
    end
    if (st_q[4].alive && $signed(st_d[5].e[2]) <= $signed({1'b0, min_depth_q})) begin
      st_d[5].status = ST_REJECT;
      st_d[5].alive  = 1'b0;
    end

    // Stage 6: divider setup, |q| << F over q_z
    st_d[6] = st_q[5];
    mag_x = st_q[5].e[0][31] ? -st_q[5].e[0] : st_q[5].e[0];
    mag_y = st_q[5].e[1][31] ? -st_q[5].e[1] : st_q[5].e[1];
    st_d[6].neg_x   = st_q[5].e[0][31];
    st_d[6].neg_y   = st_q[5].e[1][31];
    st_d[6].rq_x    = QW'(mag_x) << FRAC_BITS;
    st_d[6].rq_y    = QW'(mag_y) << FRAC_BITS;
    st_d[6].rem_x   = '0;
    st_d[6].rem_y   = '0;
    st_d[6].divisor = st_q[5].alive ? st_q[5].e[2][30:0] : 31'd1;

    // Restoring divider: one quotient bit per stage
    for (int j = 0; j < QW; j++) begin
      st_d[DIV0+j] = st_q[DIV0+j-1];
      tx = {st_q[DIV0+j-1].rem_x, st_q[DIV0+j-1].rq_x[QW-1]};
      ty = {st_q[DIV0+j-1].rem_y, st_q[DIV0+j-1].rq_y[QW-1]};
      gx = tx >= {1'b0, st_q[DIV0+j-1].divisor};
      gy = ty >= {1'b0, st_q[DIV0+j-1].divisor};
      st_d[DIV0+j].rem_x = gx ? 31'(tx - {1'b0, st_q[DIV0+j-1].divisor}) : tx[30:0];
      st_d[DIV0+j].rem_y = gy ? 31'(ty - {1'b0, st_q[DIV0+j-1].divisor}) : ty[30:0];
      st_d[DIV0+j].rq_x  = {st_q[DIV0+j-1].rq_x[QW-2:0], gx};
      st_d[DIV0+j].rq_y  = {st_q[DIV0+j-1].rq_y[QW-2:0], gy};
    end

    // Residual magnitudes, clamped
    st_d[RES] = st_q[RES-1];
    ux = st_q[RES-1].neg_x ? -$signed({1'b0, st_q[RES-1].rq_x})
                           : $signed({1'b0, st_q[RES-1].rq_x});
    uy = st_q[RES-1].neg_y ? -$signed({1'b0, st_q[RES-1].rq_y})
                           : $signed({1'b0, st_q[RES-1].rq_y});
    st_d[RES].m_x = mag_clamp((QW+2)'($signed(st_q[RES-1].ox)) - (QW+2)'(ux));
    st_d[RES].m_y = mag_clamp((QW+2)'($signed(st_q[RES-1].oy)) - (QW+2)'(uy));

    // Squares
    st_d[SQ] = st_q[RES];
    st_d[SQ].prod[0] = 64'(st_q[RES].m_x) * 64'(st_q[RES].m_x);
    st_d[SQ].prod[1] = 64'(st_q[RES].m_y) * 64'(st_q[RES].m_y);

    // Gate and mask the world point
    st_d[OUTS] = st_q[SQ];
    if (st_q[SQ].alive && (65'(st_q[SQ].prod[0]) + 65'(st_q[SQ].prod[1]))
        >= 65'(res_limit_q)) begin
      st_d[OUTS].status = ST_REJECT;
      st_d[OUTS].alive  = 1'b0;
    end
    if (!st_d[OUTS].alive) begin
      st_d[OUTS].w = '0;
    end
  end

  // Advance each stage when the one after it is free or moving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (mv[0]) begin
        v_q[0] <= in_accept;
      end
      for (int k = 1; k < NS; k++) begin
        if (mv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (mv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o   = v_q[NS-1];
  assign out_status_o  = st_q[NS-1].status;
  assign out_world_x_o = st_q[NS-1].w[0];
  assign out_world_y_o = st_q[NS-1].w[1];
  assign out_world_z_o = st_q[NS-1].w[2];

`ifndef ASSERT_OFF
  a_pose_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_func_i == FUNC_POSE) |-> !feat_busy)
    else $error("pose load taken while a feature reads the pose words");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> v_q[0])
    else $error("accepted transaction missing from first stage");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[RES-1] && st_q[RES-1].alive) |->
      (st_q[RES-1].rem_x < st_q[RES-1].divisor &&
       st_q[RES-1].rem_y < st_q[RES-1].divisor))
    else $error("divider remainder not below divisor");

  a_out_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !st_q[NS-1].alive) |->
      (out_world_x_o == 0 && out_world_y_o == 0 && out_world_z_o == 0))
    else $error("world point not cleared for a rejected or skipped item");
`endif

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for depth_point_lift_reprojection_gate
// Loads camera poses, streams features through both lift branches with
// random idling on both channels and checks every result in order against
// a bit-exact fixed point predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
  import dplrg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    func_e              func;
    logic [4:0]         slot;
    logic signed [31:0] word;
    logic               placed;
    logic               has_a;
    logic               has_b;
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic [30:0]        da;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic [30:0]        db;
  } gate_in_t;

  typedef struct {
    status_e            status;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } gate_out_t;

  class LiftScoreboard;
    longint    pose[24];
    bit [30:0] min_depth;
    bit [39:0] res_limit;
    gate_out_t expected_points[$];
    int        errors;
    int        seen[5];
    longint    world[3];
    longint    proj[3];

    function new();
      foreach (pose[i]) pose[i] = 0;
      min_depth = MIN_DEPTH_RST;
      res_limit = RES_LIMIT_RST;
      errors = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, bit [39:0] v);
      if (idx == CFG_MIN_DEPTH) min_depth = v[30:0];
      else res_limit = v;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint mulq(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC - 1));
      return p >>> FRAC;
    endfunction

    // world = R^T (p - t) through the pose starting at base
    function void lift(int base, longint x, longint y, longint d);
      longint p[3];
      longint e[3];
      longint acc;
      p[0] = sat32(mulq(x, d));
      p[1] = sat32(mulq(y, d));
      p[2] = d;
      for (int k = 0; k < 3; k++) e[k] = sat32(p[k] - pose[base + k*4 + 3]);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += mulq(pose[base + k*4 + i], e[k]);
        world[i] = sat32(acc);
      end
    endfunction

    function void reproj(int base);
      longint acc;
      for (int i = 0; i < 3; i++) begin
        acc = pose[base + i*4 + 3];
        for (int k = 0; k < 3; k++) acc += mulq(pose[base + i*4 + k], world[k]);
        proj[i] = sat32(acc);
      end
    endfunction

    function bit [63:0] sq_clamp(longint r);
      bit [63:0] m;
      m = (r < 0) ? -r : r;
      if (m > 64'h80000000) m = 64'h80000000;
      return m * m;
    endfunction

    function bit gate_point(int src, int dst, longint x, longint y, longint d,
                            longint ox, longint oy);
      longint    u;
      longint    v;
      longint    md;
      bit [63:0] s;
      md = longint'(min_depth);
      lift(src, x, y, d);
      reproj(dst);
      if (proj[2] <= md) return 0;
      u = (proj[0] * (longint'(1) << FRAC)) / proj[2];
      v = (proj[1] * (longint'(1) << FRAC)) / proj[2];
      s = sq_clamp(ox - u) + sq_clamp(oy - v);
      return s < res_limit;
    endfunction

    function gate_out_t predict(gate_in_t it);
      gate_out_t r;
      longint    md;
      md = longint'(min_depth);
      r.status = ST_SKIP;
      if (it.func == FUNC_POSE) begin
        if (it.slot < POSE_SLOTS) pose[it.slot] = longint'(it.word);
        r.status = ST_POSE;
      end else if (!it.placed && it.has_a && it.has_b) begin
        if (longint'(it.da) > md)
          r.status = gate_point(0, int'(POSE_B_BASE), longint'(it.xa), longint'(it.ya),
                                longint'(it.da), longint'(it.xb), longint'(it.yb))
                     ? ST_VIA_A : ST_REJECT;
        else if (longint'(it.db) > md)
          r.status = gate_point(int'(POSE_B_BASE), 0, longint'(it.xb), longint'(it.yb),
                                longint'(it.db), longint'(it.xa), longint'(it.ya))
                     ? ST_VIA_B : ST_REJECT;
      end
      if (r.status == ST_VIA_A || r.status == ST_VIA_B) begin
        r.wx = world[0][31:0];
        r.wy = world[1][31:0];
        r.wz = world[2][31:0];
      end else begin
        r.wx = '0;
        r.wy = '0;
        r.wz = '0;
      end
      return r;
    endfunction

    function void note_input(gate_in_t it);
      expected_points.insert(expected_points.size(), predict(it));
    endfunction

    function void check_result(gate_out_t got);
      gate_out_t exp_r;
      if (expected_points.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, got.status);
        errors++;
        return;
      end
      exp_r = expected_points.pop_front();
      if (got.status <= ST_POSE) seen[got.status]++;
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.wx !== exp_r.wx) begin
        $display("%0t: world_x expected %0d actual %0d", $time, exp_r.wx, got.wx);
        errors++;
      end
      if (got.wy !== exp_r.wy) begin
        $display("%0t: world_y expected %0d actual %0d", $time, exp_r.wy, got.wy);
        errors++;
      end
      if (got.wz !== exp_r.wz) begin
        $display("%0t: world_z expected %0d actual %0d", $time, exp_r.wz, got.wz);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [39:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               in_func_i;
  logic [4:0]         in_pose_slot_i;
  logic signed [31:0] in_pose_word_i;
  logic               in_placed_i;
  logic               in_has_a_i;
  logic               in_has_b_i;
  logic signed [31:0] in_xa_i;
  logic signed [31:0] in_ya_i;
  logic [30:0]        in_da_i;
  logic signed [31:0] in_xb_i;
  logic signed [31:0] in_yb_i;
  logic [30:0]        in_db_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         out_status_o;
  logic signed [31:0] out_world_x_o;
  logic signed [31:0] out_world_y_o;
  logic signed [31:0] out_world_z_o;

  depth_point_lift_reprojection_gate DUT (.*);

  LiftScoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_func_i = 1'b0;
    in_pose_slot_i = '0;
    in_pose_word_i = '0;
    in_placed_i = 1'b0;
    in_has_a_i = 1'b0;
    in_has_b_i = 1'b0;
    in_xa_i = '0;
    in_ya_i = '0;
    in_da_i = '0;
    in_xb_i = '0;
    in_yb_i = '0;
    in_db_i = '0;
    out_ready_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(negedge clk_i) begin
    gate_out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(out_status_o);
      got.wx = out_world_x_o;
      got.wy = out_world_y_o;
      got.wz = out_world_z_o;
      sb.check_result(got);
    end
  end

  task automatic send(gate_in_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_func_i      <= it.func;
    in_pose_slot_i <= it.slot;
    in_pose_word_i <= it.word;
    in_placed_i    <= it.placed;
    in_has_a_i     <= it.has_a;
    in_has_b_i     <= it.has_b;
    in_xa_i        <= it.xa;
    in_ya_i        <= it.ya;
    in_da_i        <= it.da;
    in_xb_i        <= it.xb;
    in_yb_i        <= it.yb;
    in_db_i        <= it.db;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    sb.note_input(it);
    sent++;
  endtask

  // hold input low and wait out every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [39:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic gate_in_t blank_item();
    gate_in_t it;
    it.func = FUNC_FEATURE;
    it.slot = 5'($urandom());
    it.word = $urandom();
    it.placed = 1'b0;
    it.has_a = 1'b1;
    it.has_b = 1'b1;
    it.xa = $urandom();
    it.ya = $urandom();
    it.da = 31'($urandom());
    it.xb = $urandom();
    it.yb = $urandom();
    it.db = 31'($urandom());
    return it;
  endfunction

  task automatic send_pose_word(logic [4:0] slot, logic signed [31:0] word);
    gate_in_t it;
    it = blank_item();
    it.func = FUNC_POSE;
    it.slot = slot;
    it.word = word;
    send(it);
  endtask

  // rotation is a signed axis permutation so it is exact in fixed point
  task automatic load_pose(logic [4:0] base, bit plain);
    int perm[3];
    int pick;
    longint w;
    pick = $urandom_range(0, 5);
    perm[0] = pick / 2;
    perm[1] = (perm[0] + 1 + (pick % 2)) % 3;
    perm[2] = 3 - perm[0] - perm[1];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (c == 3)
          w = plain ? longint'(0)
                    : longint'($urandom_range(0, 4 << FRAC)) - longint'(2 << FRAC);
        else if (plain)
          w = (c == r) ? longint'(1 << FRAC) : longint'(0);
        else if (c == perm[r])
          w = $urandom_range(0, 1) ? longint'(1 << FRAC) : -longint'(1 << FRAC);
        else
          w = longint'(0);
        send_pose_word(5'(int'(base) + r*4 + c), w[31:0]);
      end
    end
  endtask

  // feature whose other-view observation follows from the loaded poses,
  // offset by up to noise_amp
  task automatic make_feature(int branch, int noise_amp, output gate_in_t it);
    bit     via_b;
    longint x;
    longint y;
    longint d;
    longint u;
    longint v;
    longint md;
    md = longint'(sb.min_depth);
    it = blank_item();
    via_b = (branch == 2) || (branch == 0 && $urandom_range(0, 3) == 0);
    x = longint'($urandom_range(0, 1 << FRAC)) - longint'(1 << (FRAC - 1));
    y = longint'($urandom_range(0, 1 << FRAC)) - longint'(1 << (FRAC - 1));
    d = longint'($urandom_range(1 << (FRAC - 1), 8 << FRAC));
    if (d <= md && md < 64'h7fffffff) d = md + 1;
    if (via_b) begin
      sb.lift(int'(POSE_B_BASE), x, y, d);
      sb.reproj(0);
    end else begin
      sb.lift(0, x, y, d);
      sb.reproj(int'(POSE_B_BASE));
    end
    u = (sb.proj[2] != 0) ? (sb.proj[0] * (longint'(1) << FRAC)) / sb.proj[2] : 0;
    v = (sb.proj[2] != 0) ? (sb.proj[1] * (longint'(1) << FRAC)) / sb.proj[2] : 0;
    u = sb.sat32(u + longint'($urandom_range(0, 2*noise_amp)) - longint'(noise_amp));
    v = sb.sat32(v + longint'($urandom_range(0, 2*noise_amp)) - longint'(noise_amp));
    if (via_b) begin
      it.xb = x[31:0]; it.yb = y[31:0]; it.db = d[30:0];
      it.xa = u[31:0]; it.ya = v[31:0]; it.da = 31'($urandom_range(0, md[31:0]));
    end else begin
      it.xa = x[31:0]; it.ya = y[31:0]; it.da = d[30:0];
      it.xb = u[31:0]; it.yb = v[31:0];
    end
  endtask

  task automatic random_items(int count);
    gate_in_t it;
    int pick;
    int amp;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        amp = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 1500 : 5000);
        make_feature(0, amp, it);
      end else if (pick < 90) begin
        it = blank_item();
        it.placed = 1'($urandom());
        it.has_a = 1'($urandom());
        it.has_b = 1'($urandom());
      end else if (pick < 95) begin
        it = blank_item();
        it.func = FUNC_POSE;
        it.slot = 5'($urandom_range(24, 31));
      end else if (pick < 98) begin
        it = blank_item();
        it.func = FUNC_POSE;
      end else begin
        load_pose($urandom_range(0, 1) ? POSE_B_BASE : 5'd0, 1'b0);
        continue;
      end
      send(it);
    end
  endtask

  initial begin
    gate_in_t it;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // poses first: nothing may read an unloaded word
    load_pose(5'd0, 1'b1);
    load_pose(POSE_B_BASE, 1'b1);
    send_pose_word(POSE_B_BASE + 5'd3, 32'sd262144);

    it = blank_item(); it.placed = 1'b1; send(it);
    it = blank_item(); it.has_a = 1'b0; send(it);
    it = blank_item(); it.has_b = 1'b0; send(it);
    it = blank_item(); it.da = MIN_DEPTH_RST; it.db = '0;
    it.xa = 32'h7fffffff; it.ya = 32'h80000000; send(it);
    make_feature(1, 0, it); send(it);
    make_feature(2, 0, it); send(it);
    make_feature(1, 200000, it); send(it);
    make_feature(2, 200000, it); send(it);
    it = blank_item(); it.xa = 32'h7fffffff; it.ya = 32'h7fffffff;
    it.da = 31'h7fffffff; send(it);
    it = blank_item(); it.xa = 32'h80000000; it.ya = 32'h80000000;
    it.da = MIN_DEPTH_RST + 31'd1; send(it);
    it = blank_item(); it.da = '0; it.xb = 32'h80000000; it.db = 31'h7fffffff; send(it);
    send_pose_word(5'd31, 32'h80000000);
    send_pose_word(5'd24, 32'h7fffffff);
    // push pose B far back so the point lands behind it
    send_pose_word(POSE_B_BASE + 5'd11, -32'sd104857600);
    make_feature(1, 0, it); send(it);
    send_pose_word(POSE_B_BASE + 5'd11, 32'sd0);
    make_feature(1, 0, it); send(it);

    // no idling, reset settings
    random_items(PHASE_ITEMS);

    drain();
    write_reg(CFG_MIN_DEPTH, 40'd0);
    write_reg(CFG_RES_LIMIT, 40'hff_ffff_ffff);
    idle_pct = 45;
    load_pose(5'd0, 1'b0);
    random_items(PHASE_ITEMS);

    drain();
    write_reg(CFG_MIN_DEPTH, 40'h7fff_ffff);
    write_reg(CFG_RES_LIMIT, 40'd0);
    idle_pct = 0;
    stall_pct = 45;
    random_items(PHASE_ITEMS / 2);

    drain();
    write_reg(CFG_MIN_DEPTH, 40'($urandom_range(1 << (FRAC - 4), 1 << FRAC)));
    write_reg(CFG_RES_LIMIT, 40'($urandom_range(1 << 20, 1 << 27)));
    idle_pct = 15;
    stall_pct = 15;
    load_pose(POSE_B_BASE, 1'b0);
    random_items(PHASE_ITEMS);

    // receiver holds off while the sender keeps offering
    drain();
    write_reg(CFG_MIN_DEPTH, 40'(MIN_DEPTH_RST));
    write_reg(CFG_RES_LIMIT, RES_LIMIT_RST);
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    random_items(PHASE_ITEMS + 20);

    drain();
    idle_pct = 45;
    stall_pct = 45;
    random_items(PHASE_ITEMS + 30);

    drain();
    repeat (80) @(posedge clk_i);
    if (sb.pending() != 0) sb.errors++;
    $display("%0d transactions sent: %0d pose, %0d skipped, %0d via A, %0d via B, %0d rejected",
             sent, sb.seen[ST_POSE], sb.seen[ST_SKIP], sb.seen[ST_VIA_A],
             sb.seen[ST_VIA_B], sb.seen[ST_REJECT]);
    $display("%0d errors over %0d cycles", sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dplrg_pkg.sv
rtl/depth_point_lift_reprojection_gate.sv
dv/tb.sv
